[design/pfs_pkg.sv]
// Shared types and constants of the primitive field serializer.
`timescale 1ns / 1ps
package pfs_pkg;

	localparam int MAX_BYTES = 5;
	localparam int CNT_W     = 3;

	localparam logic [7:0] FLAG_CONT     = 8'h80;
	localparam logic [7:0] FLAG_HDR_MORE = 8'h40;
	localparam logic [7:0] NULL_MARK     = 8'h80;

	typedef enum logic [2:0] {
		CMD_BYTE   = 3'd0,
		CMD_SHORT  = 3'd1,
		CMD_INT    = 3'd2,
		CMD_VARINT = 3'd3,
		CMD_ZIGZAG = 3'd4,
		CMD_LENGTH = 3'd5,
		CMD_NULL   = 3'd6,
		CMD_UNUSED = 3'd7
	} cmd_t;

	typedef struct packed {
		logic [MAX_BYTES-1:0][7:0] bytes;
		logic [CNT_W-1:0]          count;
		logic                      err;
	} entry_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

endpackage

[design/pfs_front.sv]
// Front end: encodes one command into a queue entry and checks free space.
`timescale 1ns / 1ps
module pfs_front (
	input  logic [2:0]         command,
	input  logic signed [31:0] value,
	input  logic [15:0]        space_avail,
	output pfs_pkg::entry_t    entry,
	output logic               keep
);

	logic [31:0] u;
	logic [34:0] ux;
	logic [27:0] lx;
	logic [pfs_pkg::MAX_BYTES-1:0] more_v;
	logic [pfs_pkg::MAX_BYTES-1:0] more_l;
	logic [pfs_pkg::MAX_BYTES-1:0][7:0] enc;
	logic [pfs_pkg::CNT_W-1:0] n;
	logic [pfs_pkg::CNT_W-1:0] n_v;
	logic [pfs_pkg::CNT_W-1:0] n_l;
	pfs_pkg::cmd_t cmd;

	assign cmd = pfs_pkg::cmd_t'(command);

	always_comb begin
		if (cmd == pfs_pkg::CMD_ZIGZAG) begin
			u = {value[30:0], 1'b0} ^ {32{value[31]}};
		end else begin
			u = value;
		end
		ux = {3'b000, u};
		lx = {2'b00, u[31:6]};
		for (int i = 0; i < pfs_pkg::MAX_BYTES; i++) begin
			more_v[i] = (ux >> (7 * (i + 1))) != 35'd0;
		end
		more_l[0] = lx != 28'd0;
		for (int k = 1; k < pfs_pkg::MAX_BYTES; k++) begin
			more_l[k] = (lx >> (7 * k)) != 28'd0;
		end
		if (more_v[3])      n_v = 3'd5;
		else if (more_v[2]) n_v = 3'd4;
		else if (more_v[1]) n_v = 3'd3;
		else if (more_v[0]) n_v = 3'd2;
		else                n_v = 3'd1;
		if (more_l[3])      n_l = 3'd5;
		else if (more_l[2]) n_l = 3'd4;
		else if (more_l[1]) n_l = 3'd3;
		else if (more_l[0]) n_l = 3'd2;
		else                n_l = 3'd1;
	end

	always_comb begin
		enc  = '0;
		n    = 3'd1;
		keep = 1'b1;
		case (cmd)
			pfs_pkg::CMD_BYTE: begin
				enc[0] = value[7:0];
			end
			pfs_pkg::CMD_SHORT: begin
				enc[0] = value[15:8];
				enc[1] = value[7:0];
				n      = 3'd2;
			end
			pfs_pkg::CMD_INT: begin
				enc[0] = value[31:24];
				enc[1] = value[23:16];
				enc[2] = value[15:8];
				enc[3] = value[7:0];
				n      = 3'd4;
			end
			pfs_pkg::CMD_VARINT, pfs_pkg::CMD_ZIGZAG: begin
				for (int i = 0; i < pfs_pkg::MAX_BYTES; i++) begin
					enc[i] = {1'b0, ux[7*i +: 7]} | (more_v[i] ? pfs_pkg::FLAG_CONT : 8'h00);
				end
				n = n_v;
			end
			pfs_pkg::CMD_LENGTH: begin
				enc[0] = {2'b00, u[5:0]} | pfs_pkg::FLAG_CONT
					| (more_l[0] ? pfs_pkg::FLAG_HDR_MORE : 8'h00);
				for (int k = 1; k < pfs_pkg::MAX_BYTES; k++) begin
					enc[k] = {1'b0, lx[7*(k-1) +: 7]}
						| (more_l[k] ? pfs_pkg::FLAG_CONT : 8'h00);
				end
				n = n_l;
			end
			pfs_pkg::CMD_NULL: begin
				enc[0] = pfs_pkg::NULL_MARK;
			end
			default: begin
				keep = 1'b0;
			end
		endcase
	end

	always_comb begin
		if ({13'd0, n} > space_avail) begin
			entry.bytes = '0;
			entry.count = 3'd1;
			entry.err   = 1'b1;
		end else begin
			entry.bytes = enc;
			entry.count = n;
			entry.err   = 1'b0;
		end
	end

endmodule

[design/pfs_queue.sv]
// Short entry queue between front and back end.
`timescale 1ns / 1ps
module pfs_queue #(
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  pfs_pkg::entry_t  wr_data,
	input  logic             rd_en,
	output pfs_pkg::entry_t  rd_data,
	output pfs_pkg::q_stat_t stat
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	pfs_pkg::entry_t mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] p);
		if (p == PTR_W'(DEPTH - 1)) begin
			return '0;
		end
		return p + 1'b1;
	endfunction

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= wrap_inc(wr_ptr_q);
			end
			if (rd_en) begin
				rd_ptr_q <= wrap_inc(rd_ptr_q);
			end
			if (wr_en && !rd_en) begin
				count_q <= count_q + 1'b1;
			end else if (rd_en && !wr_en) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	assign rd_data    = mem_q[rd_ptr_q];
	assign stat.full  = count_q == CNT_W'(DEPTH);
	assign stat.empty = count_q == '0;

endmodule

[design/pfs_back.sv]
// Back end: walks the head entry and emits one byte beat per cycle while entries are queued and pop takes each beat.
`timescale 1ns / 1ps
module pfs_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            q_empty,
	input  pfs_pkg::entry_t head,
	output logic            deq,
	input  logic            pop,
	output logic            empty,
	output logic [7:0]      out_byte,
	output logic            last,
	output logic            status
);

	logic                      out_valid_q;
	logic [7:0]                byte_q;
	logic                      last_q;
	logic                      status_q;
	logic [pfs_pkg::CNT_W-1:0] idx_q;
	logic                      load;
	logic                      head_last;

	assign load      = !out_valid_q || pop;
	assign head_last = idx_q == (head.count - 1'b1);
	assign deq       = load && !q_empty && head_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			idx_q       <= '0;
		end else if (load) begin
			out_valid_q <= !q_empty;
			if (!q_empty) begin
				idx_q <= head_last ? '0 : idx_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load && !q_empty) begin
			byte_q   <= head.bytes[idx_q];
			last_q   <= head_last;
			status_q <= head.err;
		end
	end

	assign empty    = !out_valid_q;
	assign out_byte = byte_q;
	assign last     = last_q;
	assign status   = status_q;

endmodule

[design/primitive_field_serializer.sv]
// Top level of the primitive field serializer.
// An accepted item is written into the entry queue; its bytes reach the ports through the output byte register.
// Throughput: one beat per cycle while pop takes each beat; an item yields 1 to 5 beats,
// one per encoded byte, through the single output byte register.
// The front end takes an item per cycle while the entry queue has room.
// Reset: arst_n clears queue pointers and count, the byte index and the output valid flag at once.
`timescale 1ns / 1ps
module primitive_field_serializer #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  logic [2:0]         command,
	input  logic signed [31:0] value,
	input  logic [15:0]        space_avail,
	output logic               empty,
	input  logic               pop,
	output logic [7:0]         out_byte,
	output logic               last,
	output logic               status
);

	pfs_pkg::entry_t  fr_entry;
	pfs_pkg::entry_t  head;
	pfs_pkg::q_stat_t q_stat;
	logic             keep;
	logic             enq;
	logic             deq;

	pfs_front u_front (
		.command     (command),
		.value       (value),
		.space_avail (space_avail),
		.entry       (fr_entry),
		.keep        (keep)
	);

	assign enq  = push && !q_stat.full && keep;
	assign full = q_stat.full;

	pfs_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (enq),
		.wr_data (fr_entry),
		.rd_en   (deq),
		.rd_data (head),
		.stat    (q_stat)
	);

	pfs_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_empty  (q_stat.empty),
		.head     (head),
		.deq      (deq),
		.pop      (pop),
		.empty    (empty),
		.out_byte (out_byte),
		.last     (last),
		.status   (status)
	);

	a_err_last: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && status) |-> last)
		else $error("no_space beat not marked last");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && status) |-> (out_byte == 8'h00))
		else $error("no_space beat carries data");

	a_no_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && pop && !last) |=> !empty)
		else $error("gap inside a multi-byte encoding");

endmodule
